[rtl/itaf_pkg.sv]
package itaf_pkg;

  localparam int ValueW     = 64;
  localparam int DigitSlots = 20;
  localparam int DigitBits  = DigitSlots * 4;
  localparam int DigitPadW  = DigitBits - ValueW;
  localparam int DigIdxW    = $clog2(DigitSlots);
  localparam int BitsPerStep = 2;
  localparam int ConvSteps  = ValueW / BitsPerStep;
  localparam int ConvCntW   = $clog2(ConvSteps);
  localparam int QueueDepth = 2;
  localparam int QPtrW      = $clog2(QueueDepth);

  localparam logic [7:0] CharZero   = 8'h30;
  localparam logic [7:0] CharLowerA = 8'h61;
  localparam logic [3:0] DigitTen   = 4'd10;
  localparam logic [3:0] DabbleLim  = 4'd5;
  localparam logic [3:0] DabbleAdd  = 4'd3;

  typedef logic [DigitSlots-1:0][3:0] digits_t;

  // One queued conversion job, with width and room already saturated.
  typedef struct packed {
    logic [ValueW-1:0] value;
    logic              hex;
    logic [7:0]        pad;
    logic [6:0]        width;
    logic [8:0]        room;
  } item_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CONV,
    ST_COUNT,
    ST_EMIT
  } back_state_t;

  // One shift-and-add-3 step of the binary to BCD conversion.
  function automatic digits_t dabble_step(digits_t d, logic in_bit);
    digits_t adj;
    adj = d;
    for (int i = 0; i < DigitSlots; i++) begin
      if (adj[i] >= DabbleLim) begin
        adj[i] = adj[i] + DabbleAdd;
      end
    end
    return digits_t'({adj[DigitSlots-1:0], in_bit} >> 0);
  endfunction

  function automatic logic [7:0] to_ascii(logic [3:0] d);
    logic [7:0] ch;
    if (d >= DigitTen) begin
      ch = CharLowerA + {4'b0, d} - {4'b0, DigitTen};
    end else begin
      ch = CharZero + {4'b0, d};
    end
    return ch;
  endfunction

endpackage

[rtl/itaf_front.sv]
module itaf_front #(
  parameter int BUF_DEPTH = 256,
  parameter int MAX_WIDTH = 64
) (
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [63:0]           in_value,
  input  logic                  in_mode,
  input  logic [7:0]            in_pad_char,
  input  logic [6:0]            in_field_width,
  input  logic [8:0]            in_room,
  input  logic                  q_full,
  output logic                  q_push,
  output itaf_pkg::item_t       q_item
);

  always_comb begin
    q_item.value = in_value;
    q_item.hex   = in_mode;
    q_item.pad   = in_pad_char;
    // Oversized width and room requests are clamped to the limits.
    if (int'(in_field_width) > MAX_WIDTH) begin
      q_item.width = 7'(MAX_WIDTH);
    end else begin
      q_item.width = in_field_width;
    end
    if (int'(in_room) > BUF_DEPTH) begin
      q_item.room = 9'(BUF_DEPTH);
    end else begin
      q_item.room = in_room;
    end
  end

  assign in_ready = !q_full;
  assign q_push   = in_valid && !q_full;

endmodule

[rtl/itaf_queue.sv]
module itaf_queue (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  itaf_pkg::item_t push_item,
  output logic            full,
  output logic            pop_valid,
  output itaf_pkg::item_t pop_item,
  input  logic            pop
);

  itaf_pkg::item_t                mem_r [itaf_pkg::QueueDepth];
  logic [itaf_pkg::QPtrW-1:0]     wr_ptr_r, wr_ptr_nxt;
  logic [itaf_pkg::QPtrW-1:0]     rd_ptr_r, rd_ptr_nxt;
  logic [itaf_pkg::QPtrW:0]       cnt_r, cnt_nxt;
  logic                           do_push, do_pop;

  assign full      = (cnt_r == (itaf_pkg::QPtrW+1)'(itaf_pkg::QueueDepth));
  assign pop_valid = (cnt_r != '0);
  assign pop_item  = mem_r[rd_ptr_r];
  assign do_push   = push && !full;
  assign do_pop    = pop && pop_valid;

  always_comb begin
    wr_ptr_nxt = do_push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = do_pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_item;
    end
  end

endmodule

[rtl/itaf_back.sv]
module itaf_back (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            q_valid,
  input  itaf_pkg::item_t q_item,
  output logic            q_pop,
  output logic            out_valid,
  input  logic            out_ready,
  output logic [7:0]      out_char,
  output logic            out_last,
  output logic            out_overflow
);

  itaf_pkg::back_state_t            state_r, state_nxt;
  logic [itaf_pkg::ConvCntW-1:0]    conv_cnt_r, conv_cnt_nxt;
  logic [itaf_pkg::ValueW-1:0]      val_r, val_nxt;
  itaf_pkg::digits_t                digs_r, digs_nxt;
  logic [7:0]                       pad_r, pad_nxt;
  logic [6:0]                       width_r, width_nxt;
  logic [8:0]                       room_r, room_nxt;
  logic [6:0]                       npad_r, npad_nxt;
  logic [itaf_pkg::DigIdxW-1:0]     pos_r, pos_nxt;
  logic                             ovf_r, ovf_nxt;
  logic                             out_valid_r, out_valid_nxt;
  logic [7:0]                       out_char_r, out_char_nxt;
  logic                             out_last_r, out_last_nxt;
  logic                             out_ovf_r, out_ovf_nxt;

  logic [itaf_pkg::DigIdxW-1:0]     ndig;
  logic [6:0]                       total;
  logic                             slot_free;
  itaf_pkg::digits_t                dab;

  // Digit count: highest nonzero digit position, at least one digit.
  always_comb begin
    ndig = itaf_pkg::DigIdxW'(1);
    for (int i = 1; i < itaf_pkg::DigitSlots; i++) begin
      if (digs_r[i] != 4'd0) begin
        ndig = itaf_pkg::DigIdxW'(i + 1);
      end
    end
    total = (width_r > 7'(ndig)) ? width_r : 7'(ndig);
  end

  assign slot_free = !out_valid_r || out_ready;

  always_comb begin
    state_nxt     = state_r;
    conv_cnt_nxt  = conv_cnt_r;
    val_nxt       = val_r;
    digs_nxt      = digs_r;
    pad_nxt       = pad_r;
    width_nxt     = width_r;
    room_nxt      = room_r;
    npad_nxt      = npad_r;
    pos_nxt       = pos_r;
    ovf_nxt       = ovf_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_char_nxt  = out_char_r;
    out_last_nxt  = out_last_r;
    out_ovf_nxt   = out_ovf_r;
    q_pop         = 1'b0;
    dab           = digs_r;
    case (state_r)
      itaf_pkg::ST_IDLE: begin
        if (q_valid) begin
          q_pop     = 1'b1;
          val_nxt   = q_item.value;
          pad_nxt   = q_item.pad;
          width_nxt = q_item.width;
          room_nxt  = q_item.room;
          if (q_item.hex) begin
            digs_nxt  = itaf_pkg::digits_t'({{itaf_pkg::DigitPadW{1'b0}}, q_item.value});
            state_nxt = itaf_pkg::ST_COUNT;
          end else begin
            digs_nxt     = '0;
            conv_cnt_nxt = '0;
            state_nxt    = itaf_pkg::ST_CONV;
          end
        end
      end
      itaf_pkg::ST_CONV: begin
        for (int b = 0; b < itaf_pkg::BitsPerStep; b++) begin
          dab = itaf_pkg::dabble_step(dab, val_r[itaf_pkg::ValueW-1-b]);
        end
        digs_nxt     = dab;
        val_nxt      = val_r << itaf_pkg::BitsPerStep;
        conv_cnt_nxt = conv_cnt_r + 1'b1;
        if (conv_cnt_r == itaf_pkg::ConvCntW'(itaf_pkg::ConvSteps - 1)) begin
          state_nxt = itaf_pkg::ST_COUNT;
        end
      end
      itaf_pkg::ST_COUNT: begin
        npad_nxt  = total - 7'(ndig);
        pos_nxt   = ndig - 1'b1;
        ovf_nxt   = ({2'b0, total} > room_r);
        state_nxt = itaf_pkg::ST_EMIT;
      end
      itaf_pkg::ST_EMIT: begin
        if (slot_free) begin
          out_valid_nxt = 1'b1;
          if (ovf_r) begin
            out_char_nxt = 8'd0;
            out_last_nxt = 1'b1;
            out_ovf_nxt  = 1'b1;
            state_nxt    = itaf_pkg::ST_IDLE;
          end else if (npad_r != 7'd0) begin
            out_char_nxt = pad_r;
            out_last_nxt = 1'b0;
            out_ovf_nxt  = 1'b0;
            npad_nxt     = npad_r - 1'b1;
          end else begin
            out_char_nxt = itaf_pkg::to_ascii(digs_r[pos_r]);
            out_last_nxt = (pos_r == '0);
            out_ovf_nxt  = 1'b0;
            pos_nxt      = pos_r - 1'b1;
            if (pos_r == '0) begin
              state_nxt = itaf_pkg::ST_IDLE;
            end
          end
        end
      end
      default: begin
        state_nxt = itaf_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= itaf_pkg::ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    conv_cnt_r <= conv_cnt_nxt;
    val_r      <= val_nxt;
    digs_r     <= digs_nxt;
    pad_r      <= pad_nxt;
    width_r    <= width_nxt;
    room_r     <= room_nxt;
    npad_r     <= npad_nxt;
    pos_r      <= pos_nxt;
    ovf_r      <= ovf_nxt;
    out_char_r <= out_char_nxt;
    out_last_r <= out_last_nxt;
    out_ovf_r  <= out_ovf_nxt;
  end

  assign out_valid    = out_valid_r;
  assign out_char     = out_char_r;
  assign out_last     = out_last_r;
  assign out_overflow = out_ovf_r;

endmodule

[rtl/integer_to_ascii_formatter_top.sv]
// Channel   Ports                                               Direction
// input     in_valid/in_ready, in_value, in_mode, in_pad_char,  into block
//           in_field_width, in_room
// result    out_valid/out_ready, out_char, out_last,            out of block
//           out_overflow
//
// A decimal item first runs the binary to BCD shift-add loop, two bits per cycle,
// and then a count step sizes the field; a hexadecimal item goes straight to the
// count step. Emission runs at one character per cycle while out_ready allows it,
// through a single output register.
// Reset (rst_n low, synchronous) empties the job queue and drops any result.
// A stalled result channel holds the converter; the two-entry queue keeps
// taking input transfers until it is full.
module integer_to_ascii_formatter_top #(
  parameter int BUF_DEPTH = 256,
  parameter int MAX_WIDTH = 64
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [63:0] in_value,
  input  logic        in_mode,
  input  logic [7:0]  in_pad_char,
  input  logic [6:0]  in_field_width,
  input  logic [8:0]  in_room,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  out_char,
  output logic        out_last,
  output logic        out_overflow
);

  // Jobs travel from the front end to the converter through a short queue,
  // so that input transfers and result transfers stall independently.
  itaf_pkg::item_t push_item;
  itaf_pkg::item_t pop_item;
  logic            q_push;
  logic            q_full;
  logic            q_valid;
  logic            q_pop;

  // The front end clamps the width and room requests and classifies the job.
  itaf_front #(
    .BUF_DEPTH (BUF_DEPTH),
    .MAX_WIDTH (MAX_WIDTH)
  ) u_front (
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_value       (in_value),
    .in_mode        (in_mode),
    .in_pad_char    (in_pad_char),
    .in_field_width (in_field_width),
    .in_room        (in_room),
    .q_full         (q_full),
    .q_push         (q_push),
    .q_item         (push_item)
  );

  itaf_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_item (push_item),
    .full      (q_full),
    .pop_valid (q_valid),
    .pop_item  (pop_item),
    .pop       (q_pop)
  );

  // The converter turns the value into digits, sizes the field, checks it
  // against the room left, and streams pad and digit characters out.
  itaf_back u_back (
    .clk          (clk),
    .rst_n        (rst_n),
    .q_valid      (q_valid),
    .q_item       (pop_item),
    .q_pop        (q_pop),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_char     (out_char),
    .out_last     (out_last),
    .out_overflow (out_overflow)
  );

endmodule

[rtl/itaf_checker.sv]
module itaf_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] out_char,
  input logic       out_last,
  input logic       out_overflow
);

  // An overflow result is the only result of its item.
  a_ovf_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_overflow |-> out_last)
    else $error("overflow result without last");

  a_ovf_char: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_overflow |-> out_char == 8'd0)
    else $error("overflow result carries a character");

  // The final character of a normal item is always a digit.
  a_last_digit: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_last && !out_overflow |->
      ((out_char >= 8'h30 && out_char <= 8'h39) ||
       (out_char >= 8'h61 && out_char <= 8'h66)))
    else $error("final character is not a digit");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_char) &&
      $stable(out_last) && $stable(out_overflow))
    else $error("stalled result changed");

  a_reset: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid right after reset");

endmodule

bind integer_to_ascii_formatter_top itaf_checker u_itaf_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .out_valid    (out_valid),
  .out_ready    (out_ready),
  .out_char     (out_char),
  .out_last     (out_last),
  .out_overflow (out_overflow)
);

[bench/integer_to_ascii_formatter_top_tb.sv]
`timescale 1ns / 1ps

module integer_to_ascii_formatter_top_tb;

  localparam int BufDepth       = 256;
  localparam int MaxWidth       = 64;
  localparam int ResetCycles    = 9;
  localparam int RandomPerPhase = 82;
  localparam int DrainCycles    = 80;
  localparam int CycleLimit     = 1_000_000;
  localparam int NumRows        = 25;
  localparam int NumPhases      = 4;

  // How the expected characters of a directed row are obtained: from the
  // predictor, from the literal text typed into the table, or as the single
  // overflow result.
  typedef enum logic [1:0] {
    CHECK_MODEL,
    CHECK_TEXT,
    CHECK_OVF
  } check_kind_t;

  typedef struct packed {
    logic [63:0] value;
    logic        hex;
    logic [7:0]  pad;
    logic [6:0]  width;
    logic [8:0]  room;
    check_kind_t kind;
  } stim_row_t;

  // One expected character transfer on the result channel.
  typedef struct packed {
    logic [7:0] ch;
    logic       last;
    logic       ovf;
  } char_exp_t;

  localparam char_exp_t OverflowMark = '{8'h00, 1'b1, 1'b1};

  logic        clk;
  logic        rst_n          = 1'b0;
  logic        in_valid       = 1'b0;
  logic        in_ready;
  logic [63:0] in_value       = '0;
  logic        in_mode        = 1'b0;
  logic [7:0]  in_pad_char    = '0;
  logic [6:0]  in_field_width = '0;
  logic [8:0]  in_room        = '0;
  logic        out_valid;
  logic        out_ready      = 1'b0;
  logic [7:0]  out_char;
  logic        out_last;
  logic        out_overflow;

  // Characters still owed by the block, oldest first.
  char_exp_t pending_chars[$];

  int mismatch_count = 0;
  int cycle_count    = 0;

  // Idle and stall probabilities in percent, changed from phase to phase.
  int send_idle_pct  = 0;
  int recv_stall_pct = 0;

  // The directed rows cover zero in both radixes, the largest value in both
  // radixes, exact fits next to overflows by one, digit count boundaries,
  // width saturation above 64, room saturation above 256 and odd pad bytes.
  stim_row_t dir_rows [NumRows] = '{
    '{64'd0,                   1'b0, 8'h20, 7'd0,   9'd256, CHECK_TEXT},
    '{64'd0,                   1'b1, 8'h20, 7'd0,   9'd1,   CHECK_TEXT},
    '{64'd0,                   1'b0, 8'h20, 7'd0,   9'd0,   CHECK_OVF},
    '{64'hffff_ffff_ffff_ffff, 1'b0, 8'h20, 7'd0,   9'd256, CHECK_TEXT},
    '{64'hffff_ffff_ffff_ffff, 1'b1, 8'h20, 7'd0,   9'd16,  CHECK_TEXT},
    '{64'hffff_ffff_ffff_ffff, 1'b1, 8'h20, 7'd0,   9'd15,  CHECK_OVF},
    '{64'hffff_ffff_ffff_ffff, 1'b0, 8'h20, 7'd20,  9'd20,  CHECK_TEXT},
    '{64'hffff_ffff_ffff_ffff, 1'b0, 8'h20, 7'd0,   9'd19,  CHECK_OVF},
    '{64'h0123_4567_89ab_cdef, 1'b1, 8'h30, 7'd0,   9'd256, CHECK_TEXT},
    '{64'd1234,                1'b0, 8'h2a, 7'd8,   9'd8,   CHECK_TEXT},
    '{64'd1234,                1'b0, 8'h2a, 7'd8,   9'd7,   CHECK_OVF},
    '{64'd10000000000000000000, 1'b0, 8'h20, 7'd0,  9'd20,  CHECK_TEXT},
    '{64'd9,                   1'b0, 8'h20, 7'd0,   9'd1,   CHECK_TEXT},
    '{64'd10,                  1'b0, 8'h20, 7'd0,   9'd2,   CHECK_TEXT},
    '{64'd15,                  1'b1, 8'h20, 7'd0,   9'd1,   CHECK_TEXT},
    '{64'd16,                  1'b1, 8'h20, 7'd0,   9'd2,   CHECK_TEXT},
    '{64'd5,                   1'b1, 8'h30, 7'd64,  9'd256, CHECK_MODEL},
    '{64'd5,                   1'b0, 8'hff, 7'd127, 9'd64,  CHECK_MODEL},
    '{64'd5,                   1'b0, 8'hff, 7'd127, 9'd63,  CHECK_OVF},
    '{64'd5,                   1'b1, 8'h00, 7'd65,  9'd511, CHECK_MODEL},
    '{64'hffff_ffff_ffff_ffff, 1'b0, 8'h7f, 7'd100, 9'd300, CHECK_MODEL},
    '{64'd7,                   1'b0, 8'h00, 7'd3,   9'd256, CHECK_MODEL},
    '{64'h8000_0000_0000_0000, 1'b1, 8'h30, 7'd17,  9'd17,  CHECK_TEXT},
    '{64'd0,                   1'b0, 8'h55, 7'd64,  9'd511, CHECK_MODEL},
    '{64'd42,                  1'b0, 8'h20, 7'd5,   9'd5,   CHECK_TEXT}
  };

  // Literal expected text for the CHECK_TEXT rows; unused entries are empty.
  string dir_text [NumRows] = '{
    "0", "0", "",
    "18446744073709551615", "ffffffffffffffff", "",
    "18446744073709551615", "",
    "123456789abcdef", "****1234", "",
    "10000000000000000000", "9", "10", "f", "10",
    "", "", "", "", "", "",
    "08000000000000000", "", "   42"
  };

  integer_to_ascii_formatter_top #(
    .BUF_DEPTH (BufDepth),
    .MAX_WIDTH (MaxWidth)
  ) dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_value       (in_value),
    .in_mode        (in_mode),
    .in_pad_char    (in_pad_char),
    .in_field_width (in_field_width),
    .in_room        (in_room),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_char       (out_char),
    .out_last       (out_last),
    .out_overflow   (out_overflow)
  );

  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  task automatic flag_mismatch(input string msg);
    $display("ERROR cycle %0d: %s", cycle_count, msg);
    mismatch_count++;
  endtask

  // Produces the digits of a value least significant first, in the chosen
  // radix, and returns how many there are. Zero still yields one digit.
  function automatic int render_digits(input logic [63:0] v, input logic hex,
                                       output logic [itaf_pkg::DigitSlots-1:0][7:0] txt);
    logic [63:0] rest;
    logic [3:0]  d;
    int          n;
    rest = v;
    n = 0;
    txt = '0;
    do begin
      if (hex) begin
        d = rest[3:0];
        rest = rest >> 4;
      end else begin
        d = 4'(rest % 64'd10);
        rest = rest / 64'd10;
      end
      txt[n] = (d >= 4'd10) ? itaf_pkg::CharLowerA + 8'(d) - 8'd10 :
                              itaf_pkg::CharZero + 8'(d);
      n++;
    end while (rest != 0 && n < itaf_pkg::DigitSlots);
    return n;
  endfunction

  // Number of characters an item would emit: the saturated width or the digit
  // count, whichever is larger.
  function automatic int field_length(input logic [63:0] v, input logic hex,
                                      input logic [6:0] width);
    logic [itaf_pkg::DigitSlots-1:0][7:0] txt;
    int ndig;
    int w;
    ndig = render_digits(v, hex, txt);
    w = (width > MaxWidth) ? MaxWidth : int'(width);
    return (ndig < w) ? w : ndig;
  endfunction

  // Predicts the character stream of one accepted item and queues it.
  function automatic void format_number(input stim_row_t r);
    logic [itaf_pkg::DigitSlots-1:0][7:0] txt;
    int ndig;
    int total;
    int space;
    ndig = render_digits(r.value, r.hex, txt);
    total = field_length(r.value, r.hex, r.width);
    space = (r.room > BufDepth) ? BufDepth : int'(r.room);
    if (space < total) begin
      pending_chars.push_back(OverflowMark);
      return;
    end
    for (int i = 0; i < total - ndig; i++) begin
      pending_chars.push_back(char_exp_t'{r.pad, 1'b0, 1'b0});
    end
    for (int i = ndig; i > 0; i--) begin
      pending_chars.push_back(char_exp_t'{txt[i-1], i == 1, 1'b0});
    end
  endfunction

  // Presents one item and returns at the edge where it is accepted. Valid is
  // only dropped during an idle gap, so a back-to-back item keeps it high.
  task automatic send_item(input stim_row_t r);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid       <= 1'b1;
    in_value       <= r.value;
    in_mode        <= r.hex;
    in_pad_char    <= r.pad;
    in_field_width <= r.width;
    in_room        <= r.room;
    @(posedge clk);
    while (!in_ready) begin
      @(posedge clk);
    end
  endtask

  // Result side: checks every completed transfer against the oldest queued
  // character, then picks the ready level for the next cycle.
  always @(posedge clk) begin
    char_exp_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_chars.size() == 0) begin
        flag_mismatch($sformatf("unexpected result char=%02h last=%0b ovf=%0b",
                                out_char, out_last, out_overflow));
      end else begin
        want = pending_chars.pop_front();
        if (out_char !== want.ch || out_last !== want.last ||
            out_overflow !== want.ovf) begin
          flag_mismatch($sformatf("char=%02h/%02h last=%0b/%0b ovf=%0b/%0b (got/exp)",
                                  out_char, want.ch, out_last, want.last,
                                  out_overflow, want.ovf));
        end
      end
    end
    out_ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // Watchdog: the worst legal run is far below this many cycles.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("Mismatches found");
      $finish;
    end
  end

  initial begin
    stim_row_t r;
    int        need;
    int        pick;

    repeat (ResetCycles) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (int phase = 0; phase < NumPhases; phase++) begin
      // Phase 0 runs flat out, then the sender idles heavily, then the
      // receiver stalls heavily, then both pause now and then.
      case (phase)
        0: begin
          send_idle_pct  = 0;
          recv_stall_pct = 0;
        end
        1: begin
          send_idle_pct  = 88;
          recv_stall_pct = 0;
        end
        2: begin
          send_idle_pct  = 0;
          recv_stall_pct = 88;
        end
        default: begin
          send_idle_pct  = 18;
          recv_stall_pct = 18;
        end
      endcase

      if (phase == 0) begin
        for (int i = 0; i < NumRows; i++) begin
          send_item(dir_rows[i]);
          case (dir_rows[i].kind)
            CHECK_TEXT: begin
              for (int k = 0; k < dir_text[i].len(); k++) begin
                pending_chars.push_back(char_exp_t'{dir_text[i][k],
                                                    k == dir_text[i].len() - 1,
                                                    1'b0});
              end
            end
            CHECK_OVF: pending_chars.push_back(OverflowMark);
            default:   format_number(dir_rows[i]);
          endcase
        end
      end

      for (int n = 0; n < RandomPerPhase; n++) begin
        r.hex  = 1'($urandom_range(1));
        r.pad  = 8'($urandom_range(255));
        r.kind = CHECK_MODEL;

        // Values: fully random, small, random with a random number of leading
        // zero bits, or right at a digit count boundary of the chosen radix.
        case ($urandom_range(3))
          0: r.value = {$urandom, $urandom};
          1: r.value = 64'($urandom_range(99));
          2: r.value = {$urandom, $urandom} >> $urandom_range(63);
          default: begin
            if (r.hex) begin
              r.value = 64'd1 << (4 * $urandom_range(15));
            end else begin
              r.value = 64'd1;
              repeat ($urandom_range(19)) r.value = r.value * 64'd10;
            end
            r.value = r.value - 64'($urandom_range(1));
          end
        endcase

        // Mostly narrow fields, sometimes up to the saturation point and
        // sometimes anywhere in the 7-bit range.
        pick = $urandom_range(99);
        if (pick < 60) begin
          r.width = 7'($urandom_range(24));
        end else if (pick < 85) begin
          r.width = 7'($urandom_range(64));
        end else begin
          r.width = 7'($urandom_range(127));
        end

        // Room: usually enough, often an exact fit or one short, and
        // otherwise anywhere in the 9-bit range.
        need = field_length(r.value, r.hex, r.width);
        pick = $urandom_range(99);
        if (pick < 50) begin
          r.room = 9'(need + $urandom_range(20));
        end else if (pick < 70) begin
          r.room = 9'(need - $urandom_range(1));
        end else begin
          r.room = 9'($urandom_range(511));
        end

        send_item(r);
        format_number(r);
      end
    end
    in_valid <= 1'b0;

    // Let the block finish what is owed, then watch for stray results.
    while (pending_chars.size() != 0) begin
      @(posedge clk);
    end
    repeat (DrainCycles) @(posedge clk);

    if (mismatch_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
